### rtl/inactivity_sleep_policy_macros.svh
// Assertion macros for the inactivity sleep policy block.
// Expects clk and rst in the scope of the including module.
`ifndef INACTIVITY_SLEEP_POLICY_MACROS_SVH
`define INACTIVITY_SLEEP_POLICY_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ISP_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ISP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/isp_pkg.sv
// Shared types, codes and constants of the inactivity sleep policy block.
// No dependencies; used by isp_policy and inactivity_sleep_policy.
`default_nettype none

package isp_pkg;

  localparam int DEFAULT_TIME_BITS = 48;

  localparam int MS_W   = 27;                 // millisecond quantities
  localparam int US_W   = 37;                 // timeouts in microseconds
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEP_TIMEOUT  = 1'b1;

  localparam logic [MS_W-1:0] LIGHT_RESET_MS = MS_W'(10000);
  localparam logic [MS_W-1:0] DEEP_RESET_MS  = MS_W'(60000);
  localparam longint MS_TO_US = 1000;

  // floor(x / 1000) for x < 2^US_W: x = hi * 2^SPLIT + lo,
  // x = hi * SPLIT_QUO * 1000 + (hi * SPLIT_REM + lo)
  localparam int SPLIT   = 20;
  localparam int HI_W    = US_W - SPLIT;
  localparam int Y_W     = 27;
  localparam int Q_W     = 28;
  localparam longint SPLIT_QUO = (64'd1 << SPLIT) / MS_TO_US;
  localparam longint SPLIT_REM = (64'd1 << SPLIT) % MS_TO_US;

  // reciprocal of 1000, exact for y < 2^Y_W
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_W     = 28;
  localparam int PROD_W      = Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / MS_TO_US);

  typedef enum logic [2:0] {
    MODE_POLL       = 3'd0,
    MODE_ACTIVITY   = 3'd1,
    MODE_LIGHT_DONE = 3'd2,
    MODE_BUTTON     = 3'd3,
    MODE_REQUEST    = 3'd4,
    MODE_START      = 3'd5,
    MODE_RELEASE    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_DEEP    = 3'd1,
    ST_LIGHT   = 3'd2,
    ST_REFUSED = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef struct packed {
    mode_t mode;
    logic  button_released;
    logic  light_ok;
    logic  woke_by_button;
    logic  activity_wake;
    logic  deadline_reached;
  } item_t;

  typedef struct packed {
    status_t         status;
    logic            sleep_requested;
    logic            button_reserved;
    logic            monitor_active;
    logic [US_W-1:0] inactive;       // nonzero only with a light claim
  } verdict_t;

endpackage

`default_nettype wire

### rtl/inactivity_sleep_policy.sv
// Top level of the inactivity sleep policy: request register, policy step,
// rounding pipeline for deep_left_ms. Depends on isp_pkg, isp_policy, macros.
//
//   channel   signals                          handshake
//   request   mode, now_us, flag bits          req_valid / req_ready
//   result    status, deep_left_ms, flags      res_valid / res_ready
//   config    cfg_index, cfg_data              cfg_we, no wait
//
// One request per cycle sustained while res_ready holds; a result leaves the
// request register through the split, multiply and output registers.
// Each stage holds while the next is full; bubbles collapse, so a request is
// taken while a result waits. Reset clears policy state and restores timeouts.
`default_nettype none

module inactivity_sleep_policy #(
  parameter int TIME_BITS = isp_pkg::DEFAULT_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [isp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [isp_pkg::MS_W-1:0]      cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [2:0]                    mode,
  input  logic [TIME_BITS-1:0]          now_us,
  input  logic                          button_released,
  input  logic                          light_ok,
  input  logic                          woke_by_button,
  input  logic                          activity_wake,
  input  logic                          deadline_reached,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [2:0]                    status,
  output logic [isp_pkg::MS_W-1:0]      deep_left_ms,
  output logic                          sleep_requested,
  output logic                          button_reserved,
  output logic                          monitor_active
);
  import isp_pkg::*;
  `include "inactivity_sleep_policy_macros.svh"

  // timeouts
  logic [US_W-1:0] light_us;
  logic [US_W-1:0] deep_us;
  logic [MS_W-1:0] deep_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_us <= US_W'(LIGHT_RESET_MS) * US_W'(MS_TO_US);
      deep_us  <= US_W'(DEEP_RESET_MS) * US_W'(MS_TO_US);
      deep_ms  <= DEEP_RESET_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT_TIMEOUT: light_us <= US_W'(cfg_data) * US_W'(MS_TO_US);
        CFG_DEEP_TIMEOUT: begin
          deep_us <= US_W'(cfg_data) * US_W'(MS_TO_US);
          deep_ms <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // stage handshake
  logic s0_valid, p1_valid, p2_valid;
  logic s0_free, p1_free, p2_free, p3_free;
  logic step;

  assign p3_free   = !res_valid || res_ready;
  assign p2_free   = !p2_valid || p3_free;
  assign p1_free   = !p1_valid || p2_free;
  assign s0_free   = !s0_valid || p1_free;
  assign req_ready = s0_free;
  assign step      = s0_valid && p1_free;

  // request register
  item_t                s0_item;
  logic [TIME_BITS-1:0] s0_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_free) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && s0_free) begin
      s0_item.mode             <= mode_t'(mode);
      s0_item.button_released  <= button_released;
      s0_item.light_ok         <= light_ok;
      s0_item.woke_by_button   <= woke_by_button;
      s0_item.activity_wake    <= activity_wake;
      s0_item.deadline_reached <= deadline_reached;
      s0_now                   <= now_us;
    end
  end

  verdict_t verdict;

  isp_policy #(
    .TIME_BITS(TIME_BITS)
  ) u_policy (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (s0_item),
    .now_us  (s0_now),
    .light_us(light_us),
    .deep_us (deep_us),
    .verdict (verdict)
  );

  // rounding pipeline: remaining = deep_ms - floor(inactive / 1000)
  verdict_t             p1_verdict, p2_verdict;
  logic [HI_W-1:0]      p1_hi;
  logic [Y_W-1:0]       p1_y;
  logic [MS_W-1:0]      p1_deep_ms, p2_deep_ms;
  logic [PROD_W-1:0]    p2_prod;
  logic [Q_W-1:0]       p2_hi_quo;
  logic [Q_W-1:0]       quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (p1_free) p1_valid <= s0_valid;
      if (p2_free) p2_valid <= p1_valid;
      if (p3_free) res_valid <= p2_valid;
    end
  end

  assign quot = p2_hi_quo + Q_W'(p2_prod[PROD_W-1:RECIP_SHIFT]);

  always_ff @(posedge clk) begin
    if (step) begin
      p1_verdict <= verdict;
      p1_hi      <= verdict.inactive[US_W-1:SPLIT];
      p1_y       <= Y_W'(Y_W'(verdict.inactive[US_W-1:SPLIT]) * Y_W'(SPLIT_REM))
                    + Y_W'(verdict.inactive[SPLIT-1:0]);
      p1_deep_ms <= (verdict.status == ST_LIGHT) ? deep_ms : '0;
    end
    if (p1_valid && p2_free) begin
      p2_verdict <= p1_verdict;
      p2_prod    <= PROD_W'(p1_y) * PROD_W'(RECIP);
      p2_hi_quo  <= Q_W'(p1_hi) * Q_W'(SPLIT_QUO);
      p2_deep_ms <= p1_deep_ms;
    end
    if (p2_valid && p3_free) begin
      status          <= p2_verdict.status;
      sleep_requested <= p2_verdict.sleep_requested;
      button_reserved <= p2_verdict.button_reserved;
      monitor_active  <= p2_verdict.monitor_active;
      deep_left_ms    <= MS_W'(Q_W'(p2_deep_ms) - quot);
    end
  end

  `ISP_ASSERT_IMP(a_rem_only_light, res_valid && (status != ST_LIGHT),
                  deep_left_ms == '0, "deep_left_ms set without a light claim")
  `ISP_ASSERT_IMP(a_light_has_rem, res_valid && (status == ST_LIGHT),
                  deep_left_ms != '0, "light claim with zero remaining time")
  `ISP_ASSERT_IMP(a_claim_pending, res_valid && (status == ST_DEEP || status == ST_REFUSED),
                  sleep_requested, "deep claim or refusal without pending request")
  `ISP_ASSERT_ALWAYS(a_stall_full, req_ready || (s0_valid && p1_valid && p2_valid && res_valid),
                     "request stalled while pipeline has a bubble")

endmodule

`default_nettype wire

### rtl/isp_policy.sv
// Policy state and per-request decision logic.
// Depends on isp_pkg; state advances on step.
`default_nettype none

module isp_policy #(
  parameter int TIME_BITS = isp_pkg::DEFAULT_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  isp_pkg::item_t         item,
  input  logic [TIME_BITS-1:0]   now_us,
  input  logic [isp_pkg::US_W-1:0] light_us,
  input  logic [isp_pkg::US_W-1:0] deep_us,
  output isp_pkg::verdict_t      verdict
);
  import isp_pkg::*;

  localparam int CW = (TIME_BITS > US_W) ? TIME_BITS : US_W;

  logic monitor_on, monitor_on_next;
  logic request_pending, request_pending_next;
  logic light_active, light_active_next;
  logic button_guard, button_guard_next;
  logic light_failed, light_failed_next;
  logic policy_owns_request, policy_owns_request_next;
  logic [TIME_BITS-1:0] last_activity_us, last_activity_us_next;

  logic [TIME_BITS-1:0] inactive;
  logic [CW-1:0]        inactive_w;
  logic                 deep_hit;
  logic                 light_hit;
  status_t              status;
  logic [US_W-1:0]      claim_inactive;

  assign inactive   = now_us - last_activity_us;
  assign inactive_w = CW'(inactive);
  assign deep_hit   = inactive_w >= CW'(deep_us);
  assign light_hit  = inactive_w >= CW'(light_us);

  always_comb begin
    monitor_on_next          = monitor_on;
    request_pending_next     = request_pending;
    light_active_next        = light_active;
    button_guard_next        = button_guard;
    light_failed_next        = light_failed;
    policy_owns_request_next = policy_owns_request;
    last_activity_us_next    = last_activity_us;
    status                   = ST_NONE;
    claim_inactive           = '0;
    unique case (item.mode)
      MODE_POLL: begin
        if (request_pending) begin
          if (monitor_on && !light_active) begin
            monitor_on_next = 1'b0;
          end
        end else if (monitor_on && !light_active) begin
          if (deep_hit) begin
            request_pending_next     = 1'b1;
            policy_owns_request_next = 1'b1;
            status                   = ST_DEEP;
          end else if (!light_failed && light_hit) begin
            light_active_next = 1'b1;
            status            = ST_LIGHT;
            claim_inactive    = inactive_w[US_W-1:0];
          end
        end
      end
      MODE_ACTIVITY: begin
        if (monitor_on && !request_pending) begin
          last_activity_us_next = now_us;
          light_failed_next     = 1'b0;
        end
      end
      MODE_LIGHT_DONE: begin
        if (!light_active) begin
          status = ST_INVALID;
        end else begin
          light_active_next = 1'b0;
          if (!item.light_ok) begin
            light_failed_next = 1'b1;
          end else if (item.activity_wake) begin
            if (item.woke_by_button) begin
              button_guard_next = 1'b1;
            end
            if (!request_pending) begin
              last_activity_us_next = now_us;
              light_failed_next     = 1'b0;
            end
          end else if (item.deadline_reached) begin
            if (!request_pending) begin
              request_pending_next     = 1'b1;
              policy_owns_request_next = 1'b1;
              status                   = ST_DEEP;
            end else begin
              monitor_on_next = 1'b0;
              status          = ST_REFUSED;
            end
          end
        end
      end
      MODE_BUTTON: begin
        if (light_active || button_guard) begin
          if (item.button_released && !light_active) begin
            button_guard_next = 1'b0;
          end
        end else if (!item.button_released) begin
          if (!request_pending) begin
            request_pending_next     = 1'b1;
            policy_owns_request_next = 1'b0;
            status                   = ST_DEEP;
          end else begin
            status = ST_REFUSED;
          end
        end
      end
      MODE_REQUEST: begin
        if (!request_pending) begin
          request_pending_next     = 1'b1;
          policy_owns_request_next = 1'b0;
          status                   = ST_DEEP;
        end else begin
          status = ST_REFUSED;
        end
      end
      MODE_START: begin
        if (monitor_on) begin
          status = ST_INVALID;
        end else begin
          last_activity_us_next = now_us;
          monitor_on_next       = 1'b1;
          light_active_next     = 1'b0;
          button_guard_next     = 1'b0;
          light_failed_next     = 1'b0;
        end
      end
      MODE_RELEASE: begin
        if (!request_pending) begin
          status = ST_INVALID;
        end else begin
          request_pending_next = 1'b0;
          if (policy_owns_request) begin
            monitor_on_next   = 1'b0;
            light_active_next = 1'b0;
          end
          policy_owns_request_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_on          <= 1'b0;
      request_pending     <= 1'b0;
      light_active        <= 1'b0;
      button_guard        <= 1'b0;
      light_failed        <= 1'b0;
      policy_owns_request <= 1'b0;
      last_activity_us    <= '0;
    end else if (step) begin
      monitor_on          <= monitor_on_next;
      request_pending     <= request_pending_next;
      light_active        <= light_active_next;
      button_guard        <= button_guard_next;
      light_failed        <= light_failed_next;
      policy_owns_request <= policy_owns_request_next;
      last_activity_us    <= last_activity_us_next;
    end
  end

  always_comb begin
    verdict.status          = status;
    verdict.sleep_requested = request_pending_next;
    verdict.button_reserved = light_active_next || button_guard_next;
    verdict.monitor_active  = monitor_on_next;
    verdict.inactive        = claim_inactive;
  end

endmodule

`default_nettype wire

### tb/isp_policy_check.sv
// Watches the request, result and register ports of inactivity_sleep_policy,
// predicts each result from its own copy of the policy state, compares in order.
// Depends on isp_pkg for the mode and status codes, field widths and register indexes.
module isp_policy_check (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [isp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [isp_pkg::MS_W-1:0]              cfg_data,
  input  logic                                  req_valid,
  input  logic                                  req_ready,
  input  logic [2:0]                            mode,
  input  logic [isp_pkg::DEFAULT_TIME_BITS-1:0] now_us,
  input  logic                                  button_released,
  input  logic                                  light_ok,
  input  logic                                  woke_by_button,
  input  logic                                  activity_wake,
  input  logic                                  deadline_reached,
  input  logic                                  res_valid,
  input  logic                                  res_ready,
  input  logic [2:0]                            status,
  input  logic [isp_pkg::MS_W-1:0]              deep_left_ms,
  input  logic                                  sleep_requested,
  input  logic                                  button_reserved,
  input  logic                                  monitor_active,
  output int                                    n_open,
  output int                                    n_failed
);
  timeunit 1ns;
  timeprecision 1ps;
  import isp_pkg::*;

  localparam int TB = DEFAULT_TIME_BITS;

  typedef struct packed {
    status_t         status;
    logic [MS_W-1:0] deep_left_ms;
    logic            sleep_requested;
    logic            button_reserved;
    logic            monitor_active;
  } outcome_t;

  logic            mon_on;
  logic            req_pend;
  logic            light_act;
  logic            btn_guard;
  logic            light_fail;
  logic            owns_req;
  logic [TB-1:0]   last_act;
  logic [MS_W-1:0] light_ms;
  logic [MS_W-1:0] deep_ms;

  outcome_t outcome_q[$];
  int       failures = 0;

  initial begin
    n_open = 0;
    n_failed = 0;
  end

  function automatic outcome_t policy_outcome(input logic [2:0] m, input logic [TB-1:0] t,
                                              input logic rel, input logic ok,
                                              input logic by_btn, input logic act,
                                              input logic dl);
    logic [TB-1:0] idle_us;
    logic [63:0]   light_us;
    logic [63:0]   deep_us;
    logic [63:0]   left_ms;
    outcome_t      o;
    o.status = ST_NONE;
    o.deep_left_ms = '0;
    idle_us = t - last_act;
    light_us = 64'(light_ms) * 64'd1000;
    deep_us = 64'(deep_ms) * 64'd1000;
    case (m)
      MODE_POLL: begin
        if (req_pend) begin
          if (mon_on && !light_act) mon_on = 1'b0;
        end else if (mon_on && !light_act) begin
          if (64'(idle_us) >= deep_us) begin
            req_pend = 1'b1;
            owns_req = 1'b1;
            o.status = ST_DEEP;
          end else if (!light_fail && 64'(idle_us) >= light_us) begin
            left_ms = (deep_us - 64'(idle_us) + 64'd999) / 64'd1000;
            o.deep_left_ms = left_ms[MS_W-1:0];
            light_act = 1'b1;
            o.status = ST_LIGHT;
          end
        end
      end
      MODE_ACTIVITY: begin
        if (mon_on && !req_pend) begin
          last_act = t;
          light_fail = 1'b0;
        end
      end
      MODE_LIGHT_DONE: begin
        if (!light_act) begin
          o.status = ST_INVALID;
        end else begin
          light_act = 1'b0;
          if (!ok) begin
            light_fail = 1'b1;
          end else if (act) begin
            if (by_btn) btn_guard = 1'b1;
            if (!req_pend) begin
              last_act = t;
              light_fail = 1'b0;
            end
          end else if (dl) begin
            if (!req_pend) begin
              req_pend = 1'b1;
              owns_req = 1'b1;
              o.status = ST_DEEP;
            end else begin
              mon_on = 1'b0;
              o.status = ST_REFUSED;
            end
          end
        end
      end
      MODE_BUTTON: begin
        if (light_act || btn_guard) begin
          if (rel && !light_act) btn_guard = 1'b0;
        end else if (!rel) begin
          if (!req_pend) begin
            req_pend = 1'b1;
            owns_req = 1'b0;
            o.status = ST_DEEP;
          end else begin
            o.status = ST_REFUSED;
          end
        end
      end
      MODE_REQUEST: begin
        if (!req_pend) begin
          req_pend = 1'b1;
          owns_req = 1'b0;
          o.status = ST_DEEP;
        end else begin
          o.status = ST_REFUSED;
        end
      end
      MODE_START: begin
        if (mon_on) begin
          o.status = ST_INVALID;
        end else begin
          last_act = t;
          mon_on = 1'b1;
          light_act = 1'b0;
          btn_guard = 1'b0;
          light_fail = 1'b0;
        end
      end
      MODE_RELEASE: begin
        if (!req_pend) begin
          o.status = ST_INVALID;
        end else begin
          req_pend = 1'b0;
          if (owns_req) begin
            mon_on = 1'b0;
            light_act = 1'b0;
          end
          owns_req = 1'b0;
        end
      end
      default: ;
    endcase
    o.sleep_requested = req_pend;
    o.button_reserved = light_act || btn_guard;
    o.monitor_active = mon_on;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      mon_on = 1'b0;
      req_pend = 1'b0;
      light_act = 1'b0;
      btn_guard = 1'b0;
      light_fail = 1'b0;
      owns_req = 1'b0;
      last_act = '0;
      light_ms = LIGHT_RESET_MS;
      deep_ms = DEEP_RESET_MS;
      outcome_q.delete();
    end else begin
      if (res_valid && res_ready) begin
        got.status = status_t'(status);
        got.deep_left_ms = deep_left_ms;
        got.sleep_requested = sleep_requested;
        got.button_reserved = button_reserved;
        got.monitor_active = monitor_active;
        if (outcome_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with no request outstanding, status %0d remaining %0d",
                     $time, status, deep_left_ms);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: mismatch exp/act status %0d/%0d remaining %0d/%0d",
                        " req %0b/%0b btn %0b/%0b mon %0b/%0b"}, $time,
                       want.status, got.status, want.deep_left_ms, got.deep_left_ms,
                       want.sleep_requested, got.sleep_requested,
                       want.button_reserved, got.button_reserved,
                       want.monitor_active, got.monitor_active);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_LIGHT_TIMEOUT) light_ms = cfg_data;
        else if (cfg_index == CFG_DEEP_TIMEOUT) deep_ms = cfg_data;
      end
      if (req_valid && req_ready)
        outcome_q.push_back(policy_outcome(mode, now_us, button_released, light_ok,
                                           woke_by_button, activity_wake, deadline_reached));
    end
    n_open <= outcome_q.size();
    n_failed <= failures;
  end

endmodule

### tb/tb_inactivity_sleep_policy.sv
// Top of the inactivity_sleep_policy testbench: clock, reset, directed and random
// requests under several timeout settings, receiver stalls, watchdog and verdict.
// Depends on isp_pkg, the block itself and the isp_policy_check result checker.
module tb_inactivity_sleep_policy;
  timeunit 1ns;
  timeprecision 1ps;
  import isp_pkg::*;

  localparam int TB           = DEFAULT_TIME_BITS;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES       = 7;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] MODE_IGNORED = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MS_W-1:0]      cfg_data;
  logic                 req_valid;
  logic                 req_ready;
  logic [2:0]           mode;
  logic [TB-1:0]        now_us;
  logic                 button_released;
  logic                 light_ok;
  logic                 woke_by_button;
  logic                 activity_wake;
  logic                 deadline_reached;
  logic                 res_valid;
  logic                 res_ready;
  logic [2:0]           status;
  logic [MS_W-1:0]      deep_left_ms;
  logic                 sleep_requested;
  logic                 button_reserved;
  logic                 monitor_active;
  int                   n_open;
  int                   n_failed;

  int              sent = 0;
  int              burst_left = 0;
  int              ready_left = 0;
  int              idle_cycles = 0;
  logic [TB-1:0]   now_t = '0;
  logic [TB-1:0]   act_t = '0;
  logic [MS_W-1:0] light_cfg = LIGHT_RESET_MS;
  logic [MS_W-1:0] deep_cfg = DEEP_RESET_MS;

  inactivity_sleep_policy u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready),
    .mode(mode), .now_us(now_us), .button_released(button_released),
    .light_ok(light_ok), .woke_by_button(woke_by_button),
    .activity_wake(activity_wake), .deadline_reached(deadline_reached),
    .res_valid(res_valid), .res_ready(res_ready),
    .status(status), .deep_left_ms(deep_left_ms), .sleep_requested(sleep_requested),
    .button_reserved(button_reserved), .monitor_active(monitor_active)
  );

  isp_policy_check u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready),
    .mode(mode), .now_us(now_us), .button_released(button_released),
    .light_ok(light_ok), .woke_by_button(woke_by_button),
    .activity_wake(activity_wake), .deadline_reached(deadline_reached),
    .res_valid(res_valid), .res_ready(res_ready),
    .status(status), .deep_left_ms(deep_left_ms), .sleep_requested(sleep_requested),
    .button_reserved(button_reserved), .monitor_active(monitor_active),
    .n_open(n_open), .n_failed(n_failed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: long ready stretches mixed with short random stalls
  always @(posedge clk) begin
    if (ready_left == 0) begin
      if ($urandom_range(3, 0) == 0) begin
        res_ready <= 1'b1;
        ready_left <= $urandom_range(60, 20);
      end else begin
        res_ready <= 1'($urandom);
        ready_left <= $urandom_range(12, 1);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("inactivity_sleep_policy regression: fail");
        $finish;
      end
    end
  end

  task automatic put_request(input logic [2:0] m, input logic [TB-1:0] t,
                             input logic rel, input logic ok, input logic by_btn,
                             input logic act, input logic dl);
    req_valid <= 1'b1;
    mode <= m;
    now_us <= t;
    button_released <= rel;
    light_ok <= ok;
    woke_by_button <= by_btn;
    activity_wake <= act;
    deadline_reached <= dl;
    now_t = t;
    if (m == MODE_ACTIVITY || m == MODE_START || (m == MODE_LIGHT_DONE && ok && act))
      act_t = t;
    do @(posedge clk); while (!req_ready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(50, 0);
      req_valid <= 1'b0;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  endtask

  task automatic put_event(input logic [2:0] m, input logic [TB-1:0] t);
    put_request(m, t, 1'($urandom), $urandom_range(3, 0) != 0, 1'($urandom),
                1'($urandom), 1'($urandom));
  endtask

  // move the time cursor: near a light or deep boundary, between or past them, or at random
  function automatic logic [TB-1:0] pick_time();
    logic [63:0] lu;
    logic [63:0] du;
    lu = 64'(light_cfg) * 64'd1000;
    du = 64'(deep_cfg) * 64'd1000;
    case ($urandom_range(9, 0))
      0, 1: now_t = TB'(64'(now_t) + 64'($urandom_range(2000000, 0)));
      2: now_t = TB'(64'(act_t) + lu + 64'($urandom_range(2, 0)) - 64'd1);
      3: now_t = TB'(64'(act_t) + du + 64'($urandom_range(2, 0)) - 64'd1);
      4, 5: begin
        if (du > lu) now_t = TB'(64'(act_t) + lu + ({$urandom, $urandom} % (du - lu)));
        else now_t = TB'(64'(act_t) + lu);
      end
      6: now_t = TB'(64'(act_t) + (64'($urandom) % (lu + 64'd1)));
      7: now_t = TB'(64'(act_t) - 64'($urandom_range(1000000, 1)));
      8: now_t = TB'({$urandom, $urandom});
      default: now_t = TB'(64'(act_t) + du + 64'($urandom));
    endcase
    return now_t;
  endfunction

  initial begin
    logic [TB-1:0]   t0;
    logic [TB-1:0]   t1;
    logic [TB-1:0]   t2;
    logic [TB-1:0]   t3;
    logic [MS_W-1:0] nl;
    logic [MS_W-1:0] nd;
    int              phase_end;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LIGHT_TIMEOUT;
    cfg_data <= '0;
    req_valid <= 1'b0;
    mode <= MODE_POLL;
    now_us <= '0;
    button_released <= 1'b0;
    light_ok <= 1'b0;
    woke_by_button <= 1'b0;
    activity_wake <= 1'b0;
    deadline_reached <= 1'b0;
    res_ready <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: invalid states, wrap of time, rounding, light failure, guard, releases
    t0 = '1;
    t1 = TB'(1000);
    t2 = {1'b1, {(TB-1){1'b0}}};
    t3 = TB'(48'h1234_5678_9abc);
    put_request(MODE_POLL, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_LIGHT_DONE, '0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    put_request(MODE_RELEASE, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_IGNORED, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    put_request(MODE_START, t0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_START, t0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_POLL, t0 + TB'(9999999), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_POLL, t0 + TB'(10000000), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_LIGHT_DONE, t0 + TB'(10500000), 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    put_request(MODE_BUTTON, t0 + TB'(10600000), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_ACTIVITY, t1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_POLL, t1 + TB'(10000001), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_LIGHT_DONE, t1 + TB'(10000002), 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    put_request(MODE_POLL, t1 + TB'(20000000), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_POLL, t1 + TB'(60000000), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_REQUEST, t1 + TB'(60000001), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_POLL, t1 + TB'(60000002), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_RELEASE, t1 + TB'(60000003), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_START, t2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_BUTTON, t2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_RELEASE, t2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_POLL, t2 - TB'(1), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_RELEASE, t2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_START, t3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_POLL, t3 + TB'(59999999), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    put_request(MODE_LIGHT_DONE, t3 + TB'(59999999), 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    put_request(MODE_RELEASE, t3 + TB'(60000000), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        case (p)
          1: begin nl = MS_W'(1);        nd = MS_W'(2);        end
          2: begin nl = MS_W'(86400000); nd = MS_W'(86400000); end
          3: begin nl = MS_W'(1);        nd = MS_W'(86400000); end
          4: begin nl = MS_W'(7000);     nd = MS_W'(3000);     end
          5: begin nl = MS_W'(0);        nd = MS_W'(0);        end
          default: begin nl = MS_W'(250); nd = MS_W'(1500);   end
        endcase
        req_valid <= 1'b0;
        do @(posedge clk); while (n_open != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_LIGHT_TIMEOUT;
        cfg_data <= nl;
        @(posedge clk);
        cfg_index <= CFG_DEEP_TIMEOUT;
        cfg_data <= nd;
        @(posedge clk);
        cfg_we <= 1'b0;
        light_cfg = nl;
        deep_cfg = nd;
      end
      phase_end = sent + RANDOM_ITEMS / PHASES;
      while (sent < phase_end) begin
        if ($urandom_range(9, 0) < 7) begin
          put_event(MODE_START, pick_time());
          repeat ($urandom_range(3, 0)) put_event(MODE_ACTIVITY, pick_time());
          repeat ($urandom_range(6, 1)) begin
            put_event(MODE_POLL, pick_time());
            case ($urandom_range(5, 0))
              0: put_event(MODE_BUTTON, pick_time());
              1: put_event(MODE_REQUEST, pick_time());
              2, 3: put_event(MODE_LIGHT_DONE, pick_time());
              default: ;
            endcase
          end
          if ($urandom_range(3, 0) != 0) put_event(MODE_RELEASE, pick_time());
        end else begin
          repeat ($urandom_range(8, 1)) put_event(3'($urandom_range(7, 0)), pick_time());
        end
      end
    end

    req_valid <= 1'b0;
    do @(posedge clk); while (n_open != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_failed == 0) begin
      $display("inactivity_sleep_policy regression: pass");
    end else begin
      $display("inactivity_sleep_policy regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/isp_pkg.sv
rtl/isp_policy.sv
rtl/inactivity_sleep_policy.sv
tb/isp_policy_check.sv
tb/tb_inactivity_sleep_policy.sv
